[rtl/imc_pkg.sv]
package imc_pkg;

    // Operation codes carried in a request.
    localparam logic [2:0] OP_LCM   = 3'd1;
    localparam logic [2:0] OP_GCD   = 3'd2;
    localparam logic [2:0] OP_FACT  = 3'd3;
    localparam logic [2:0] OP_PRIME = 3'd4;
    localparam logic [2:0] OP_HYP   = 3'd5;

    // Status codes returned with each answer.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_ZERO    = 2'd2;

    localparam int RESULT_W = 64;
    localparam int CNT_W    = 7;

    // From this argument on the factorial is zero modulo 2^64.
    localparam logic [CNT_W-1:0] FACT_LIMIT = 7'd66;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GCD,
        S_GCD_DIV,
        S_LCM_DIV,
        S_FACT,
        S_PRIME_CHK,
        S_PRIME_DIV,
        S_HYP_SQA,
        S_HYP_SQB,
        S_HYP_ROOT,
        S_DONE
    } state_t;

endpackage

[rtl/imc_if.sv]
// Request channel: opcode and two operands.
interface imc_req_if #(parameter int OPERAND_WIDTH = 16);
    logic                     valid;
    logic                     ready;
    logic [2:0]               opcode;
    logic [OPERAND_WIDTH-1:0] operand_a;
    logic [OPERAND_WIDTH-1:0] operand_b;

    modport source (output valid, output opcode, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input opcode, input operand_a, input operand_b,
                    output ready);
endinterface

// Response channel: result word and status.
interface imc_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_value;
    logic [1:0]  status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink   (input valid, input result_value, input status, output ready);
endinterface

[rtl/integer_math_calculator.sv]
// Integer math calculator. Each request carries an opcode and two unsigned operands and
// yields one response: lcm (1), gcd (2), factorial modulo 2^64 (3), primality flag (4) or
// hypotenuse in fixed point with FRACTION_BITS fraction bits, truncated (5); other opcodes
// return status 1, lcm with a zero operand returns status 2. One request is worked at a
// time; gcd, lcm and the prime test share a restoring divider that retires one quotient
// bit per cycle. A gcd takes one division per Euclid step and an lcm adds one more
// division; the prime test tries each divisor up to sqrt(n); the factorial does one
// multiply per index; the hypotenuse is found one root bit per cycle. The next request
// is taken as soon as the previous answer sits in the output register.
module integer_math_calculator
    import imc_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16,
    parameter int FRACTION_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    imc_req_if.sink   req,
    imc_rsp_if.source rsp
);

    localparam int W     = OPERAND_WIDTH;
    localparam int NP    = W + FRACTION_BITS + 1;
    localparam int RAD_W = 2 * NP;
    localparam int REM_W = NP + 3;
    localparam int SQ_W  = W + 2;
    localparam int SUM_W = 2 * W + 1;

    state_t               state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    logic [2:0]           op_reg, op_next;
    logic [W-1:0]         a_reg, a_next;
    logic [W-1:0]         b_reg, b_next;
    logic [W-1:0]         x_reg, x_next;
    logic [W-1:0]         y_reg, y_next;
    logic [W-1:0]         div_rem_reg, div_rem_next;
    logic [W-1:0]         div_quo_reg, div_quo_next;
    logic [W-1:0]         div_d_reg, div_d_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [RESULT_W-1:0]  acc_reg, acc_next;
    logic [W-1:0]         d_reg, d_next;
    logic [SQ_W-1:0]      sq_reg, sq_next;
    logic [RAD_W-1:0]     rad_reg, rad_next;
    logic [NP-1:0]        root_reg, root_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [RESULT_W-1:0]  res_reg, res_next;
    logic [1:0]           sts_reg, sts_next;
    logic [RESULT_W-1:0]  out_res_reg, out_res_next;
    logic [1:0]           out_sts_reg, out_sts_next;

    logic                 req_fire;
    logic                 rsp_free;
    logic                 div_done;
    logic [W:0]           div_sh;
    logic [W:0]           div_sub;
    logic                 div_ge;
    logic [W-1:0]         mul_x, mul_y;
    logic [2*W-1:0]       mul_p;
    logic [RESULT_W-1:0]  fact_p;
    logic [SUM_W-1:0]     sq_sum;
    logic [REM_W-1:0]     rem_sh, trial;
    logic                 root_ge;

    assign req.ready        = (state_reg == S_IDLE);
    assign req_fire         = req.valid && req.ready;
    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = out_res_reg;
    assign rsp.status       = out_sts_reg;
    assign rsp_free         = !out_valid_reg || rsp.ready;

    // Shared restoring divider step: one quotient bit per cycle.
    assign div_done = (cnt_reg == CNT_W'(W));
    assign div_sh   = {div_rem_reg, div_quo_reg[W-1]};
    assign div_ge   = (div_sh >= {1'b0, div_d_reg});
    assign div_sub  = div_sh - {1'b0, div_d_reg};

    // Operand multiplier, shared by the lcm product and the two squares.
    always_comb
    begin
        mul_x = a_reg;
        mul_y = a_reg;
        case (state_reg)
            S_LCM_DIV:
            begin
                mul_x = div_quo_reg;
                mul_y = b_reg;
            end
            S_HYP_SQB:
            begin
                mul_x = b_reg;
                mul_y = b_reg;
            end
            default:
            begin
                mul_x = a_reg;
                mul_y = a_reg;
            end
        endcase
    end
    assign mul_p = mul_x * mul_y;

    // Factorial step: running product times a 7-bit index, kept modulo 2^64.
    assign fact_p = acc_reg * {{(RESULT_W-CNT_W){1'b0}}, cnt_reg};

    // Sum of squares for the hypotenuse.
    assign sq_sum = {1'b0, acc_reg[2*W-1:0]} + {1'b0, mul_p};

    // Square root step: bring down one bit pair, try to subtract 4*root+1.
    assign rem_sh  = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign root_ge = (rem_sh >= trial);

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    case (req.opcode)
                        OP_LCM:
                        begin
                            if (req.operand_a == '0 || req.operand_b == '0)
                                state_next = S_DONE;
                            else
                                state_next = S_GCD;
                        end
                        OP_GCD:   state_next = S_GCD;
                        OP_FACT:
                        begin
                            if (req.operand_a >= W'(FACT_LIMIT))
                                state_next = S_DONE;
                            else
                                state_next = S_FACT;
                        end
                        OP_PRIME:
                        begin
                            if (req.operand_a <= W'(1))
                                state_next = S_DONE;
                            else
                                state_next = S_PRIME_CHK;
                        end
                        OP_HYP:   state_next = S_HYP_SQA;
                        default:  state_next = S_DONE;
                    endcase
                end
            end
            S_GCD:
            begin
                if (y_reg != '0)
                    state_next = S_GCD_DIV;
                else if (op_reg == OP_LCM)
                    state_next = S_LCM_DIV;
                else
                    state_next = S_DONE;
            end
            S_GCD_DIV:
            begin
                if (div_done)
                    state_next = S_GCD;
            end
            S_LCM_DIV:
            begin
                if (div_done)
                    state_next = S_DONE;
            end
            S_FACT:
            begin
                if (W'(cnt_reg) > a_reg)
                    state_next = S_DONE;
            end
            S_PRIME_CHK:
            begin
                if ({2'b00, a_reg} < sq_reg)
                    state_next = S_DONE;
                else
                    state_next = S_PRIME_DIV;
            end
            S_PRIME_DIV:
            begin
                if (div_done)
                begin
                    if (div_rem_reg == '0)
                        state_next = S_DONE;
                    else
                        state_next = S_PRIME_CHK;
                end
            end
            S_HYP_SQA: state_next = S_HYP_SQB;
            S_HYP_SQB: state_next = S_HYP_ROOT;
            S_HYP_ROOT:
            begin
                if (cnt_reg == CNT_W'(NP - 1))
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and output register updates.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        div_rem_next   = div_rem_reg;
        div_quo_next   = div_quo_reg;
        div_d_next     = div_d_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        rad_next       = rad_reg;
        root_next      = root_reg;
        rem_next       = rem_reg;
        res_next       = res_reg;
        sts_next       = sts_reg;
        out_res_next   = out_res_reg;
        out_sts_next   = out_sts_reg;

        if (rsp.valid && rsp.ready)
            out_valid_next = 1'b0;

        // Any divider state steps until the quotient is complete.
        if ((state_reg inside {S_GCD_DIV, S_LCM_DIV, S_PRIME_DIV}) && !div_done)
        begin
            div_rem_next = div_ge ? div_sub[W-1:0] : div_sh[W-1:0];
            div_quo_next = {div_quo_reg[W-2:0], div_ge};
            cnt_next     = cnt_reg + CNT_W'(1);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    op_next  = req.opcode;
                    a_next   = req.operand_a;
                    b_next   = req.operand_b;
                    x_next   = req.operand_a;
                    y_next   = req.operand_b;
                    res_next = '0;
                    sts_next = ST_OK;
                    acc_next = RESULT_W'(1);
                    cnt_next = CNT_W'(2);
                    d_next   = W'(2);
                    sq_next  = SQ_W'(4);
                    case (req.opcode)
                        OP_LCM:
                        begin
                            if (req.operand_a == '0 || req.operand_b == '0)
                                sts_next = ST_ZERO;
                        end
                        OP_GCD, OP_FACT, OP_PRIME, OP_HYP: sts_next = ST_OK;
                        default: sts_next = ST_INVALID;
                    endcase
                end
            end
            S_GCD:
            begin
                div_rem_next = '0;
                cnt_next     = '0;
                div_d_next   = y_reg;
                div_quo_next = x_reg;
                if (y_reg == '0)
                begin
                    res_next     = RESULT_W'(x_reg);
                    div_d_next   = x_reg;
                    div_quo_next = a_reg;
                end
            end
            S_GCD_DIV:
            begin
                if (div_done)
                begin
                    x_next = y_reg;
                    y_next = div_rem_reg;
                end
            end
            S_LCM_DIV:
            begin
                if (div_done)
                    res_next = RESULT_W'(mul_p);
            end
            S_FACT:
            begin
                if (W'(cnt_reg) > a_reg)
                    res_next = acc_reg;
                else
                begin
                    acc_next = fact_p;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_PRIME_CHK:
            begin
                if ({2'b00, a_reg} < sq_reg)
                    res_next = RESULT_W'(1);
                div_rem_next = '0;
                div_quo_next = a_reg;
                div_d_next   = d_reg;
                cnt_next     = '0;
            end
            S_PRIME_DIV:
            begin
                if (div_done && div_rem_reg != '0)
                begin
                    sq_next = sq_reg + SQ_W'({d_reg, 1'b1});
                    d_next  = d_reg + W'(1);
                end
            end
            S_HYP_SQA:
            begin
                acc_next = RESULT_W'(mul_p);
            end
            S_HYP_SQB:
            begin
                rad_next  = RAD_W'(sq_sum) << (2 * FRACTION_BITS);
                root_next = '0;
                rem_next  = '0;
                cnt_next  = '0;
            end
            S_HYP_ROOT:
            begin
                rem_next  = root_ge ? (rem_sh - trial) : rem_sh;
                root_next = {root_reg[NP-2:0], root_ge};
                rad_next  = rad_reg << 2;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NP - 1))
                    res_next = RESULT_W'({root_reg[NP-2:0], root_ge});
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = res_reg;
                    out_sts_next   = sts_reg;
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        div_rem_reg <= div_rem_next;
        div_quo_reg <= div_quo_next;
        div_d_reg   <= div_d_next;
        cnt_reg     <= cnt_next;
        acc_reg     <= acc_next;
        d_reg       <= d_next;
        sq_reg      <= sq_next;
        rad_reg     <= rad_next;
        root_reg    <= root_next;
        rem_reg     <= rem_next;
        res_reg     <= res_next;
        sts_reg     <= sts_next;
        out_res_reg <= out_res_next;
        out_sts_reg <= out_sts_next;
    end

endmodule

[dv/integer_math_calculator_tb.sv]
module integer_math_calculator_tb;
    import imc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int DRAIN_CYCLES   = 6000;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
    } answer_t;

    logic clk;
    logic rst_n;
    bit   failed;
    int   mismatch_count;
    int   answers_checked;
    int   requests_sent;
    int   idle_cycles;

    answer_t expected_answers[$];

    imc_req_if #(.OPERAND_WIDTH(16)) req();
    imc_rsp_if                       rsp();

    integer_math_calculator #(.OPERAND_WIDTH(16), .FRACTION_BITS(16)) dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Euclid's algorithm on 64-bit values.
    function automatic logic [63:0] euclid(logic [63:0] x, logic [63:0] y);
        logic [63:0] r;
        while (y != 0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    // Exact square root of (a*a + b*b) * 2^32, truncated, on a 128-bit radicand.
    function automatic logic [63:0] hypotenuse_q16(logic [15:0] a, logic [15:0] b);
        logic [127:0] radicand;
        logic [127:0] remainder;
        logic [127:0] trial;
        logic [63:0]  root;
        radicand  = ({96'd0, a} * {96'd0, a} + {96'd0, b} * {96'd0, b}) << 32;
        remainder = '0;
        root      = '0;
        for (int i = 63; i >= 0; i--)
        begin
            remainder = (remainder << 2) | ((radicand >> (2 * i)) & 128'd3);
            trial     = ({64'd0, root} << 2) | 128'd1;
            if (remainder >= trial)
            begin
                remainder = remainder - trial;
                root      = (root << 1) | 64'd1;
            end
            else
            begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    // Predicted answer for one request.
    function automatic answer_t compute_answer(logic [2:0] op, logic [15:0] a,
                                               logic [15:0] b);
        answer_t     ans;
        logic [63:0] acc;
        ans.value  = '0;
        ans.status = ST_OK;
        case (op)
            OP_LCM:
            begin
                if (a == 0 || b == 0)
                    ans.status = ST_ZERO;
                else
                    ans.value = (64'(a) / euclid(64'(a), 64'(b))) * 64'(b);
            end
            OP_GCD:
                ans.value = euclid(64'(a), 64'(b));
            OP_FACT:
            begin
                acc = 64'd1;
                if (a >= 66)
                    acc = '0;
                else
                    for (int i = 2; i <= a; i++)
                        acc = acc * 64'(i);
                ans.value = acc;
            end
            OP_PRIME:
            begin
                ans.value = (a > 1) ? 64'd1 : 64'd0;
                for (int d = 2; d * d <= a; d++)
                    if (a % d == 0)
                        ans.value = 64'd0;
            end
            OP_HYP:
                ans.value = hypotenuse_q16(a, b);
            default:
                ans.status = ST_INVALID;
        endcase
        return ans;
    endfunction

    // Send one request, queueing its predicted answer at acceptance.
    task automatic send_request(logic [2:0] op, logic [15:0] a, logic [15:0] b);
        req.valid     <= 1'b1;
        req.opcode    <= op;
        req.operand_a <= a;
        req.operand_b <= b;
        do
            @(posedge clk);
        while (!req.ready);
        expected_answers.push_back(compute_answer(op, a, b));
        requests_sent++;
        // Random gaps between bursts.
        if ($urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic wait_for_drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (expected_answers.size() != 0)
            @(posedge clk);
    endtask

    // Receiver stall pattern: alternating stretches of stalls and full throughput.
    initial
    begin
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 9) < 3)
                rsp.ready <= ($urandom_range(0, 2) != 0);
            else if ($urandom_range(0, 9) == 0)
                rsp.ready <= 1'b1;
        end
    end

    // Compare each accepted answer with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_answers.size() == 0)
            begin
                failed = 1'b1;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected answer: value=%0h status=%0d",
                             rsp.result_value, rsp.status);
            end
            else
            begin
                answer_t exp_ans;
                exp_ans = expected_answers.pop_front();
                answers_checked++;
                if (rsp.result_value !== exp_ans.value || rsp.status !== exp_ans.status)
                begin
                    failed = 1'b1;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Mismatch: expected value=%0h status=%0d, %s%0h status=%0d",
                                 exp_ans.value, exp_ans.status, "got value=",
                                 rsp.result_value, rsp.status);
                end
            end
        end
    end

    // Watchdog on cycles with no acceptance on either channel.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired with %0d answers pending", expected_answers.size());
            $display("integer_math_calculator_tb NOT OK");
            $finish;
        end
    end

    // Operand extremes and the special cases of every operation.
    task automatic test_directed();
        send_request(3'd0, 16'd5, 16'd7);
        send_request(3'd6, 16'hFFFF, 16'hFFFF);
        send_request(3'd7, 16'd0, 16'd0);
        send_request(OP_LCM, 16'd0, 16'd9);
        send_request(OP_LCM, 16'd9, 16'd0);
        send_request(OP_LCM, 16'hFFFF, 16'hFFFE);
        send_request(OP_LCM, 16'd12, 16'd18);
        send_request(OP_GCD, 16'd0, 16'd0);
        send_request(OP_GCD, 16'd21, 16'd0);
        send_request(OP_GCD, 16'd0, 16'd35);
        send_request(OP_GCD, 16'hFFFF, 16'hAAAA);
        send_request(OP_FACT, 16'd0, 16'hFFFF);
        send_request(OP_FACT, 16'd1, 16'd3);
        send_request(OP_FACT, 16'd65, 16'd0);
        send_request(OP_FACT, 16'd66, 16'd0);
        send_request(OP_FACT, 16'hFFFF, 16'd0);
        send_request(OP_PRIME, 16'd0, 16'd0);
        send_request(OP_PRIME, 16'd1, 16'hFFFF);
        send_request(OP_PRIME, 16'd2, 16'd0);
        send_request(OP_PRIME, 16'd65521, 16'd0);
        send_request(OP_PRIME, 16'hFFFF, 16'd0);
        send_request(OP_HYP, 16'd0, 16'd0);
        send_request(OP_HYP, 16'd3, 16'd4);
        send_request(OP_HYP, 16'hFFFF, 16'hFFFF);
    endtask

    // The sender holds off until every outstanding answer has arrived.
    task automatic test_drain_pause();
        wait_for_drain();
        send_request(OP_GCD, 16'd48, 16'd36);
        send_request(OP_HYP, 16'd1, 16'd1);
        wait_for_drain();
    endtask

    // Random requests over all opcodes and full operand ranges.
    task automatic test_random(int count);
        logic [15:0] a;
        logic [15:0] b;
        for (int n = 0; n < count; n++)
        begin
            a = 16'($urandom);
            b = 16'($urandom);
            // Bias some operands small to reach the interesting factorial range.
            if ($urandom_range(0, 3) == 0)
                a = 16'($urandom_range(0, 80));
            if ($urandom_range(0, 5) == 0)
                b = 16'($urandom_range(0, 3));
            send_request(3'($urandom_range(0, 7)), a, b);
        end
    endtask

    initial
    begin
        failed          = 1'b0;
        mismatch_count  = 0;
        answers_checked = 0;
        requests_sent   = 0;
        rst_n           = 1'b0;
        req.valid     <= 1'b0;
        req.opcode    <= '0;
        req.operand_a <= '0;
        req.operand_b <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_drain_pause();
        test_random(114);
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests over all eight opcodes; %0d answers checked.",
                 requests_sent, answers_checked);
        $display("Mismatches: %0d, answers still pending: %0d",
                 mismatch_count, expected_answers.size());
        if (!failed && expected_answers.size() == 0)
            $display("integer_math_calculator_tb OK");
        else
            $display("integer_math_calculator_tb NOT OK");
        $finish;
    end

endmodule
